// ===== sv/kph_pkg.sv =====
// ----------------------------------------------------------------------------
// kph_pkg
// Shared types and constants of the key press / hold / repeat detector.
// ----------------------------------------------------------------------------
package kph_pkg;

  // fixed field widths
  localparam int unsigned PINS_W  = 8;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned KEY_W   = 3;
  localparam int unsigned MASK_W  = 64;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned ADDR_W  = 5;

  // register reset values
  localparam logic [TICK_W-1:0] LONG_RESET   = 32'd1000;
  localparam logic [TICK_W-1:0] REPEAT_RESET = 32'd200;
  localparam logic [MASK_W-1:0] MASKS_RESET  = 64'h8040_2010_0804_0201;

  // register index, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_LONG   = 2'd0,
    REG_REPEAT = 2'd1,
    REG_MASKS  = 2'd2
  } reg_idx_t;

  // what one key lane found on a scan
  typedef struct packed {
    logic fire;
    logic hold;
  } lane_evt_t;

endpackage

// ===== sv/kph_lane.sv =====
// ----------------------------------------------------------------------------
// kph_lane
// One key: press test, released / pressed / held state and time stamp.
// ----------------------------------------------------------------------------
module kph_lane #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           scan_en,
  input  logic [kph_pkg::PINS_W-1:0]     pins,
  input  logic [kph_pkg::PINS_W-1:0]     mask,
  input  logic [TIME_BITS-1:0]           now,
  input  logic [kph_pkg::TICK_W-1:0]     long_ticks,
  input  logic [kph_pkg::TICK_W-1:0]     repeat_ticks,
  output kph_pkg::lane_evt_t             evt
);

  typedef enum logic [1:0] {
    ST_RELEASED = 2'd0,
    ST_PRESSED  = 2'd1,
    ST_HELD     = 2'd2
  } mode_t;

  mode_t                 mode_r;
  mode_t                 mode_nxt;
  logic [TIME_BITS-1:0]  stamp_r;
  logic [TIME_BITS-1:0]  elapsed;
  logic [kph_pkg::TICK_W-1:0] elapsed_w;
  logic                  pressed;
  logic                  fire;

  // press test and elapsed time since the stamp
  assign pressed   = ((pins & mask) == '0);
  assign elapsed   = now - stamp_r;
  assign elapsed_w = kph_pkg::TICK_W'(elapsed);

  // next mode and event decision
  always_comb begin
    mode_nxt = mode_r;
    fire     = 1'b0;
    if (!pressed) begin
      mode_nxt = ST_RELEASED;
    end else begin
      case (mode_r)
        ST_RELEASED: begin
          mode_nxt = ST_PRESSED;
          fire     = 1'b1;
        end
        ST_PRESSED: begin
          if (elapsed_w >= long_ticks) begin
            mode_nxt = ST_HELD;
            fire     = 1'b1;
          end
        end
        default: begin
          mode_nxt = ST_HELD;
          fire     = (elapsed_w >= repeat_ticks);
        end
      endcase
    end
  end

  // an event fires on a press, a long hold or a repeat; hold marks a key that is not released
  assign evt.fire = fire;
  assign evt.hold = (mode_r != ST_RELEASED);

  // state updated on each accepted scan, stamp only when an event fires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ST_RELEASED;
      stamp_r <= '0;
    end else if (scan_en) begin
      mode_r <= mode_nxt;
      if (fire) begin
        stamp_r <= now;
      end
    end
  end

endmodule

// ===== sv/kph_merge.sv =====
// ----------------------------------------------------------------------------
// kph_merge
// Collects the lane events of one scan and sends them out in key order.
// ----------------------------------------------------------------------------
module kph_merge #(
  parameter int unsigned NUM_KEYS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  kph_pkg::lane_evt_t           evt [NUM_KEYS],
  output logic                         ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [kph_pkg::KEY_W-1:0]    out_key,
  output logic                         out_kind,
  output logic                         out_last
);

  logic [NUM_KEYS-1:0]        pend_r;
  logic [NUM_KEYS-1:0]        hold_r;
  logic [NUM_KEYS-1:0]        fire_vec;
  logic [NUM_KEYS-1:0]        hold_vec;
  logic [NUM_KEYS-1:0]        low_bit;
  logic [NUM_KEYS-1:0]        pend_nxt;
  logic [kph_pkg::KEY_W-1:0]  sel;
  logic                       advance;
  logic                       out_valid_r;
  logic [kph_pkg::KEY_W-1:0]  out_key_r;
  logic                       out_kind_r;
  logic                       out_last_r;

  // gather lane results
  always_comb begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      fire_vec[i] = evt[i].fire;
      hold_vec[i] = evt[i].hold;
    end
  end

  // lowest pending key
  assign low_bit  = pend_r & (~pend_r + NUM_KEYS'(1));
  assign pend_nxt = pend_r & (pend_r - NUM_KEYS'(1));

  always_comb begin
    sel = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        sel = kph_pkg::KEY_W'(i);
      end
    end
  end

  assign advance = (pend_r != '0) && (!out_valid_r || out_ready);
  assign ready   = (pend_r == '0);

  // pending event set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (load) begin
      pend_r <= fire_vec;
    end else if (advance) begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_r <= hold_vec;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_key_r  <= sel;
      out_kind_r <= |(low_bit & hold_r);
      out_last_r <= (pend_nxt == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_key   = out_key_r;
  assign out_kind  = out_kind_r;
  assign out_last  = out_last_r;

`ifndef ASSERT_OFF
  // a scan with events leaves them pending
  a_load_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (load && (fire_vec != '0)) |=> (pend_r != '0))
    else $error("events of a scan were dropped");

  // each sent item removes exactly one pending key
  a_adv_one: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !load) |=> ($countones(pend_r) == $countones($past(pend_r)) - 1))
    else $error("pending set did not shrink by one");

  // an item that is not last has more events behind it
  a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (pend_r != '0))
    else $error("non-last item with nothing pending");

  // no new scan while events are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != '0) |-> !load)
    else $error("scan loaded over pending events");
`endif

endmodule

// ===== sv/key_press_hold_repeat_detector.sv =====
// ----------------------------------------------------------------------------
// key_press_hold_repeat_detector
// Scans an active-low key port and reports press, hold and repeat events.
// ----------------------------------------------------------------------------
//  channel  | direction | content
//  in_      | slave     | one scan: port pins and current tick count
//  out_     | master    | one event: key index, kind in tuser, tlast at scan end
//  cfg_     | apb       | long press ticks, repeat ticks, key masks
//
//  a scan is taken when in_tvalid and in_tready are both high; all key lanes
//  update in parallel at that edge; its events then leave one per cycle
//  through the output register while out_tready is high
//  the next scan is taken once the last event of the previous one is in the
//  output register; a stalled out_tready holds the event queue
//  reset is synchronous; every key starts released with a zero stamp
// ----------------------------------------------------------------------------
module key_press_hold_repeat_detector #(
  parameter int unsigned NUM_KEYS  = 8,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // scan input
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [39:0]                     in_tdata,   // port_pins[7:0], now_ticks[39:8]
  // event output
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // key_index[2:0], zero[7:3]
  output logic                            out_tuser,  // event_kind[0]
  output logic                            out_tlast,
  // configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [kph_pkg::ADDR_W-1:0]      cfg_paddr,
  input  logic [kph_pkg::CFG_W-1:0]       cfg_pwdata,
  output logic [kph_pkg::CFG_W-1:0]       cfg_prdata,
  output logic                            cfg_pready
);

  logic [kph_pkg::TICK_W-1:0]  long_r;
  logic [kph_pkg::TICK_W-1:0]  repeat_r;
  logic [kph_pkg::MASK_W-1:0]  masks_r;
  kph_pkg::reg_idx_t           reg_idx;
  logic                        cfg_wr;
  logic                        scan_en;
  logic [kph_pkg::PINS_W-1:0]  pins;
  logic [TIME_BITS-1:0]        now;
  logic [kph_pkg::KEY_W-1:0]   out_key;
  kph_pkg::lane_evt_t          evt [NUM_KEYS];

  // configuration registers
  assign cfg_pready = 1'b1;
  assign reg_idx    = kph_pkg::reg_idx_t'(cfg_paddr[4:3]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_r   <= kph_pkg::LONG_RESET;
      repeat_r <= kph_pkg::REPEAT_RESET;
      masks_r  <= kph_pkg::MASKS_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        kph_pkg::REG_LONG:   long_r   <= cfg_pwdata[kph_pkg::TICK_W-1:0];
        kph_pkg::REG_REPEAT: repeat_r <= cfg_pwdata[kph_pkg::TICK_W-1:0];
        kph_pkg::REG_MASKS:  masks_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      kph_pkg::REG_LONG:   cfg_prdata = kph_pkg::CFG_W'(long_r);
      kph_pkg::REG_REPEAT: cfg_prdata = kph_pkg::CFG_W'(repeat_r);
      kph_pkg::REG_MASKS:  cfg_prdata = masks_r;
      default:             cfg_prdata = '0;
    endcase
  end

  // scan fields
  assign scan_en = in_tvalid && in_tready;
  assign pins    = in_tdata[kph_pkg::PINS_W-1:0];
  assign now     = in_tdata[kph_pkg::PINS_W +: TIME_BITS];

  // one lane per key
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    kph_lane #(
      .TIME_BITS (TIME_BITS)
    ) u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .scan_en      (scan_en),
      .pins         (pins),
      .mask         (masks_r[kph_pkg::PINS_W*k +: kph_pkg::PINS_W]),
      .now          (now),
      .long_ticks   (long_r),
      .repeat_ticks (repeat_r),
      .evt          (evt[k])
    );
  end

  // event serializer
  kph_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (scan_en),
    .evt       (evt),
    .ready     (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_key   (out_key),
    .out_kind  (out_tuser),
    .out_last  (out_tlast)
  );

  assign out_tdata = {5'b0, out_key};

endmodule

// ===== verif/key_press_hold_repeat_detector_tb.sv =====
// ----------------------------------------------------------------------------
// key_press_hold_repeat_detector_tb
// Drives key port scans into the detector and checks every press, hold and
// repeat event it sends out against a cycle-free predictor of the key state
// machines. The register settings cover the threshold and mask extremes, and
// time wraps past 2^32. Random stall bursts fall on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_press_hold_repeat_detector_tb;

  localparam int NUM_KEYS   = 8;
  localparam int SETTLE     = 12;
  localparam int HOLD_OFF   = 80;
  localparam int CYCLE_CAP  = 400000;

  // register index that no register answers to
  localparam logic [1:0] REG_NONE = 2'd3;

  // event kinds as carried in out_tuser
  localparam bit EVT_PRESS = 1'b0;
  localparam bit EVT_HOLD  = 1'b1;

  typedef enum logic [1:0] {
    KEY_RELEASED = 2'd0,
    KEY_PRESSED  = 2'd1,
    KEY_HELD     = 2'd2
  } key_mode_t;

  typedef struct packed {
    bit [kph_pkg::KEY_W-1:0] key;
    bit                      kind;
    bit                      last;
  } key_evt_t;

  // scoreboard: key state predictor and queue of events still due
  class key_event_board;
    bit [kph_pkg::TICK_W-1:0] long_ticks;
    bit [kph_pkg::TICK_W-1:0] repeat_ticks;
    bit [kph_pkg::MASK_W-1:0] masks;
    key_mode_t                mode [NUM_KEYS];
    bit [kph_pkg::TICK_W-1:0] stamp [NUM_KEYS];
    key_evt_t                 due_q [$];
    int unsigned              mismatches;
    int unsigned              press_seen;
    int unsigned              hold_seen;

    function new();
      long_ticks   = kph_pkg::LONG_RESET;
      repeat_ticks = kph_pkg::REPEAT_RESET;
      masks        = kph_pkg::MASKS_RESET;
      for (int k = 0; k < NUM_KEYS; k++) begin
        mode[k]  = KEY_RELEASED;
        stamp[k] = '0;
      end
      mismatches = 0;
      press_seen = 0;
      hold_seen  = 0;
    endfunction

    function void set_reg(logic [1:0] idx, bit [kph_pkg::CFG_W-1:0] value);
      case (idx)
        kph_pkg::REG_LONG:   long_ticks   = value[kph_pkg::TICK_W-1:0];
        kph_pkg::REG_REPEAT: repeat_ticks = value[kph_pkg::TICK_W-1:0];
        kph_pkg::REG_MASKS:  masks        = value;
        default: ;
      endcase
    endfunction

    function bit [kph_pkg::CFG_W-1:0] reg_value(logic [1:0] idx);
      case (idx)
        kph_pkg::REG_LONG:   return {32'b0, long_ticks};
        kph_pkg::REG_REPEAT: return {32'b0, repeat_ticks};
        kph_pkg::REG_MASKS:  return masks;
        default:             return '0;
      endcase
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    // one accepted scan: step every key lane, queue the events in key order
    function void note_scan(bit [kph_pkg::PINS_W-1:0] pins, bit [kph_pkg::TICK_W-1:0] now);
      bit [NUM_KEYS-1:0]        fired;
      bit [NUM_KEYS-1:0]        held;
      bit [kph_pkg::TICK_W-1:0] elapsed;
      bit [7:0]                 m;
      int                       last_k;
      key_evt_t                 e;
      fired  = '0;
      held   = '0;
      last_k = -1;
      for (int k = 0; k < NUM_KEYS; k++) begin
        m = masks[8*k +: 8];
        if ((pins & m) != 0) begin
          mode[k] = KEY_RELEASED;
        end else begin
          elapsed = now - stamp[k];
          case (mode[k])
            KEY_RELEASED: begin
              mode[k]  = KEY_PRESSED;
              fired[k] = 1'b1;
            end
            KEY_PRESSED: begin
              if (elapsed >= long_ticks) begin
                mode[k]  = KEY_HELD;
                fired[k] = 1'b1;
              end
            end
            default: begin
              mode[k] = KEY_HELD;
              if (elapsed >= repeat_ticks) fired[k] = 1'b1;
            end
          endcase
          if (fired[k]) begin
            stamp[k] = now;
            held[k]  = (mode[k] != KEY_PRESSED);
            last_k   = k;
          end
        end
      end
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (fired[k]) begin
          e.key  = k[kph_pkg::KEY_W-1:0];
          e.kind = held[k] ? EVT_HOLD : EVT_PRESS;
          e.last = (k == last_k);
          due_q.push_back(e);
        end
      end
    endfunction

    function void check_event(bit [kph_pkg::KEY_W-1:0] key, bit kind, bit last);
      key_evt_t e;
      if (due_q.size() == 0) begin
        report($sformatf("event with none due: key %0d kind %0d last %0d", key, kind, last));
        return;
      end
      e = due_q.pop_front();
      if (e.key != key || e.kind != kind || e.last != last)
        report($sformatf("expected key %0d kind %0d last %0d, got key %0d kind %0d last %0d",
                         e.key, e.kind, e.last, key, kind, last));
      if (e.kind == EVT_HOLD) hold_seen++;
      else press_seen++;
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [39:0]                 in_tdata = '0;    // port_pins[7:0], now_ticks[39:8]
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [7:0]                  out_tdata;        // key_index[2:0], zero[7:3]
  logic                        out_tuser;        // event_kind[0]
  logic                        out_tlast;
  logic                        cfg_psel = 1'b0;
  logic                        cfg_penable = 1'b0;
  logic                        cfg_pwrite = 1'b0;
  logic [kph_pkg::ADDR_W-1:0]  cfg_paddr = '0;
  logic [kph_pkg::CFG_W-1:0]   cfg_pwdata = '0;
  logic [kph_pkg::CFG_W-1:0]   cfg_prdata;
  logic                        cfg_pready;

  key_event_board              board = new();
  bit                          idle_on = 1'b1;
  bit                          hold_req = 1'b0;
  int unsigned                 cycles = 0;
  int unsigned                 scans_sent = 0;
  int unsigned                 settings = 0;
  bit [kph_pkg::PINS_W-1:0]    cur_pins;
  bit [kph_pkg::TICK_W-1:0]    cur_now;

  key_press_hold_repeat_detector dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycles < CYCLE_CAP) @(posedge clk) cycles++;
    $display("key_press_hold_repeat_detector_tb: done, errors");
    $finish;
  end

  // event monitor
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        board.check_event(out_tdata[kph_pkg::KEY_W-1:0], out_tuser, out_tlast);
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // offer one scan, with an optional idle burst first
  task automatic send_scan(input bit [kph_pkg::PINS_W-1:0] pins,
                           input bit [kph_pkg::TICK_W-1:0] now);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {now, pins};
    do @(posedge clk); while (!in_tready);
    board.note_scan(pins, now);
    scans_sent++;
  endtask

  // stop offering, wait for every due event, then let the block settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx,
                            input logic [kph_pkg::CFG_W-1:0] wdata,
                            output logic [kph_pkg::CFG_W-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // write a register, read it back where it exists
  task automatic write_reg(input logic [1:0] idx, input logic [kph_pkg::CFG_W-1:0] value);
    logic [kph_pkg::CFG_W-1:0] rd;
    apb_access(1'b1, idx, value, rd);
    board.set_reg(idx, value);
    if (idx != REG_NONE) begin
      apb_access(1'b0, idx, '0, rd);
      if (rd !== board.reg_value(idx))
        board.report($sformatf("register %0d read expected %h, got %h",
                               idx, board.reg_value(idx), rd));
    end
  endtask

  task automatic apply_cfg(input bit [kph_pkg::TICK_W-1:0] long_t,
                           input bit [kph_pkg::TICK_W-1:0] rep_t,
                           input bit [kph_pkg::MASK_W-1:0] masks);
    wait_idle();
    write_reg(kph_pkg::REG_LONG, {32'b0, long_t});
    write_reg(kph_pkg::REG_REPEAT, {32'b0, rep_t});
    write_reg(kph_pkg::REG_MASKS, masks);
    settings++;
  endtask

  // per-key masks: one or two pins, any nonzero byte with any_byte, or none where zero_pct allows
  function automatic bit [kph_pkg::MASK_W-1:0] rand_masks(int zero_pct, bit any_byte);
    bit [kph_pkg::MASK_W-1:0] m;
    m = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if ($urandom_range(0, 99) < zero_pct)
        m[8*k +: 8] = 8'h00;
      else if (any_byte)
        m[8*k +: 8] = 8'($urandom_range(1, 255));
      else
        m[8*k +: 8] = (8'h01 << $urandom_range(0, 7)) | (8'h01 << $urandom_range(0, 7));
    end
    return m;
  endfunction

  // random scans: key patterns mostly kept or changed by one pin, time mostly creeping
  task automatic run_random(int count, int step_max, int hold_at, int pause_at);
    int r;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (i == pause_at) wait_idle();
      r = $urandom_range(0, 99);
      if (r < 10) cur_pins = kph_pkg::PINS_W'($urandom_range(0, 255));
      else if (r < 55) cur_pins ^= (8'h01 << $urandom_range(0, 7));
      else if (r < 60) cur_pins = 8'h00;
      r = $urandom_range(0, 99);
      if (r < 4) cur_now = $urandom();
      else if (r >= 14) cur_now += $urandom_range(1, step_max);
      send_scan(cur_pins, cur_now);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: press, long hold, repeat, partial release
    send_scan(8'hFF, 32'd0);
    send_scan(8'h00, 32'd10);
    send_scan(8'h00, 32'd500);
    send_scan(8'h00, 32'd1010);
    send_scan(8'h00, 32'd1209);
    send_scan(8'h00, 32'd1210);
    send_scan(8'h0F, 32'd1300);
    send_scan(8'h00, 32'd1400);
    // time wrap across 2^32
    send_scan(8'h00, 32'hFFFF_FF00);
    send_scan(8'hFF, 32'hFFFF_FF10);
    send_scan(8'h00, 32'hFFFF_FFF0);
    send_scan(8'h00, 32'd980);
    send_scan(8'h00, 32'd984);

    // zero thresholds, zero mask bytes; a write to an unused index
    apply_cfg(32'd0, 32'd0, 64'h00FF_0030_000C_0003);
    write_reg(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_scan(8'hFF, 32'd5);
    send_scan(8'hFF, 32'd5);
    send_scan(8'hFF, 32'd5);
    send_scan(8'h00, 32'd5);

    // largest thresholds, every pin on every key
    apply_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_scan(8'h01, 32'h8000_0000);
    send_scan(8'h00, 32'h8000_0001);
    send_scan(8'h00, 32'h8000_0000);
    send_scan(8'h00, 32'h8000_0000);
    send_scan(8'h00, 32'h7FFF_FFFF);

    // all masks zero: every key always pressed
    apply_cfg(32'd3, 32'd1, 64'h0);
    send_scan(8'hAA, 32'd100);
    send_scan(8'h55, 32'd103);

    // random phases
    cur_pins = kph_pkg::PINS_W'($urandom_range(0, 255));
    cur_now  = $urandom();
    apply_cfg($urandom_range(20, 80), $urandom_range(5, 30), rand_masks(0, 1'b0));
    run_random(130, 40, -1, 60);

    apply_cfg($urandom_range(0, 10), $urandom_range(0, 5), rand_masks(25, 1'b1));
    run_random(120, 8, 40, -1);

    cur_now = 32'hFFFF_F000 + $urandom_range(0, 255);
    apply_cfg($urandom_range(100, 600), $urandom_range(20, 150), kph_pkg::MASKS_RESET);
    run_random(120, 200, -1, -1);

    // closing stretch with no stalls on either side
    apply_cfg($urandom_range(30, 60), $urandom_range(10, 20), rand_masks(10, 1'b0));
    idle_on = 1'b0;
    run_random(80, 40, -1, -1);

    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d events never arrived", board.pending()));

    $display("covered %0d scans over %0d register settings, %0d press and %0d hold events",
             scans_sent, settings, board.press_seen, board.hold_seen);
    $display("mismatches: %0d", board.mismatches);
    if (board.mismatches == 0) begin
      $display("key_press_hold_repeat_detector_tb: done, clean");
    end else begin
      $display("key_press_hold_repeat_detector_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== key_press_hold_repeat_detector.f =====
sv/kph_pkg.sv
sv/kph_lane.sv
sv/kph_merge.sv
sv/key_press_hold_repeat_detector.sv
verif/key_press_hold_repeat_detector_tb.sv
